// File: sv/asmlex_pkg.sv
// Shared constants, character helpers and search unit types for the assembler lexer.
package asmlex_pkg;

    localparam int MAX_TOKEN_CHARS_DEF = 8;
    localparam int TABLE_SLOTS_DEF     = 64;
    localparam int MNEMONIC_CHARS_DEF  = 4;

    localparam int CHAR_W       = 8;
    localparam int TEXT_W       = 64;
    localparam int TEXT_CHARS   = TEXT_W / CHAR_W;
    localparam int ENTRY_W      = 32;
    localparam int ENTRY_CHARS  = ENTRY_W / CHAR_W;
    localparam int KIND_W       = 4;
    localparam int LEN_W        = 4;
    localparam int INDEX_W      = 6;
    localparam int COUNT_W      = 7;
    localparam int SLOT_FIELD_W = 8;

    localparam logic [KIND_W-1:0] KIND_COLON    = 4'd0;
    localparam logic [KIND_W-1:0] KIND_EOL      = 4'd1;
    localparam logic [KIND_W-1:0] KIND_HASH     = 4'd2;
    localparam logic [KIND_W-1:0] KIND_COMMA    = 4'd3;
    localparam logic [KIND_W-1:0] KIND_COMMAND  = 4'd4;
    localparam logic [KIND_W-1:0] KIND_NUMBER   = 4'd5;
    localparam logic [KIND_W-1:0] KIND_LABEL    = 4'd6;
    localparam logic [KIND_W-1:0] KIND_MNEMONIC = 4'd7;
    localparam logic [KIND_W-1:0] KIND_UNKNOWN  = 4'd8;

    localparam logic [CHAR_W-1:0] CH_NUL        = 8'h00;
    localparam logic [CHAR_W-1:0] CH_NEWLINE    = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE      = 8'h20;
    localparam logic [CHAR_W-1:0] CH_HASH       = 8'h23;
    localparam logic [CHAR_W-1:0] CH_DOLLAR     = 8'h24;
    localparam logic [CHAR_W-1:0] CH_COMMA      = 8'h2C;
    localparam logic [CHAR_W-1:0] CH_DOT        = 8'h2E;
    localparam logic [CHAR_W-1:0] CH_ZERO       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_NINE       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_COLON      = 8'h3A;
    localparam logic [CHAR_W-1:0] CH_UPPER_A    = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_Z    = 8'h5A;
    localparam logic [CHAR_W-1:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [CHAR_W-1:0] CH_LOWER_A    = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_Z    = 8'h7A;
    localparam logic [CHAR_W-1:0] CASE_OFFSET   = 8'h20;

    typedef struct packed {
        logic                    start;
        logic                    wr_en;
        logic [SLOT_FIELD_W-1:0] wr_addr;
        logic [ENTRY_W-1:0]      wr_data;
    } srch_req_t;

    typedef struct packed {
        logic               done;
        logic               hit;
        logic [INDEX_W-1:0] slot;
    } srch_rsp_t;

    function automatic logic is_word_char(logic [CHAR_W-1:0] c);
        return (c >= CH_LOWER_A && c <= CH_LOWER_Z) || (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
               (c >= CH_ZERO && c <= CH_NINE) || c == CH_UNDERSCORE || c == CH_DOLLAR;
    endfunction

    function automatic logic [CHAR_W-1:0] fold_case(logic [CHAR_W-1:0] c);
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z)
        begin
            return c + CASE_OFFSET;
        end
        return c;
    endfunction

endpackage

// File: sv/asmlex_if.sv
// Handshake channels for source items and result tokens.
interface asmlex_in_if;
    import asmlex_pkg::*;
    logic                valid;
    logic                ready;
    logic                opcode;
    logic [CHAR_W-1:0]   char_in;
    logic [INDEX_W-1:0]  entry_index;
    logic [ENTRY_W-1:0]  entry_text;

    modport source (output valid, opcode, char_in, entry_index, entry_text, input ready);
    modport sink (input valid, opcode, char_in, entry_index, entry_text, output ready);
endinterface

interface asmlex_out_if;
    import asmlex_pkg::*;
    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   token_kind;
    logic [TEXT_W-1:0]   token_text;
    logic [LEN_W-1:0]    token_length;
    logic                truncated;
    logic [INDEX_W-1:0]  mnemonic_index;
    logic                last_of_run;

    modport source (output valid, token_kind, token_text, token_length, truncated,
                    mnemonic_index, last_of_run, input ready);
    modport sink (input valid, token_kind, token_text, token_length, truncated,
                  mnemonic_index, last_of_run, output ready);
endinterface

// File: sv/asmlex_ram.sv
// Generic single-write, single-read RAM with registered read data.
module asmlex_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// File: sv/asmlex_search.sv
// Mnemonic table storage and slot-by-slot first-match search.
module asmlex_search import asmlex_pkg::*; #(
    parameter int TABLE_SLOTS    = TABLE_SLOTS_DEF,
    parameter int MNEMONIC_CHARS = MNEMONIC_CHARS_DEF,
    localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1,
    localparam int CNT_W  = $clog2(TABLE_SLOTS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  srch_req_t          req,
    input  logic [CNT_W-1:0]   limit,
    input  logic [ENTRY_W-1:0] word_text,
    input  logic [LEN_W-1:0]   word_length,
    output srch_rsp_t          rsp
);

    localparam int CMP_CHARS = (MNEMONIC_CHARS < ENTRY_CHARS) ? MNEMONIC_CHARS : ENTRY_CHARS;

    logic              busy_reg, busy_next;
    logic [CNT_W-1:0]  issue_reg, issue_next;
    logic              chk_valid_reg, chk_valid_next;
    logic [SLOT_W-1:0] chk_slot_reg, chk_slot_next;

    logic [SLOT_W-1:0]  rd_addr;
    logic [ENTRY_W-1:0] entry;
    logic [LEN_W-1:0]   elen;
    logic               stop;
    logic               same;
    logic               match;
    logic               last_chk;
    logic               done;

    asmlex_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TABLE_SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (req.wr_en),
        .wr_addr (req.wr_addr[SLOT_W-1:0]),
        .wr_data (req.wr_data),
        .rd_addr (rd_addr),
        .rd_data (entry)
    );

    assign rd_addr = req.start ? '0 : issue_reg[SLOT_W-1:0];

    // entry length: first zero byte or the per-entry character limit
    always_comb
    begin
        elen = '0;
        stop = 1'b0;
        same = 1'b1;
        for (int i = 0; i < ENTRY_CHARS; i++)
        begin
            if (i < CMP_CHARS && !stop && entry[i*CHAR_W +: CHAR_W] != CH_NUL)
            begin
                elen = elen + 1'b1;
            end
            else
            begin
                stop = 1'b1;
            end
        end
        for (int i = 0; i < ENTRY_CHARS; i++)
        begin
            if (LEN_W'(i) < elen &&
                fold_case(entry[i*CHAR_W +: CHAR_W]) != fold_case(word_text[i*CHAR_W +: CHAR_W]))
            begin
                same = 1'b0;
            end
        end
    end

    assign match    = same && (elen == word_length);
    assign last_chk = (CNT_W'(chk_slot_reg) == limit - CNT_W'(1));
    assign done     = busy_reg && chk_valid_reg && (match || last_chk);

    assign rsp.done = done;
    assign rsp.hit  = match;
    assign rsp.slot = INDEX_W'(chk_slot_reg);

    always_comb
    begin
        busy_next      = busy_reg;
        issue_next     = issue_reg;
        chk_valid_next = chk_valid_reg;
        chk_slot_next  = chk_slot_reg;
        if (req.start)
        begin
            busy_next      = 1'b1;
            issue_next     = CNT_W'(1);
            chk_valid_next = 1'b1;
            chk_slot_next  = '0;
        end
        else if (busy_reg)
        begin
            if (done)
            begin
                busy_next      = 1'b0;
                chk_valid_next = 1'b0;
            end
            else if (issue_reg < limit)
            begin
                chk_valid_next = 1'b1;
                chk_slot_next  = issue_reg[SLOT_W-1:0];
                issue_next     = issue_reg + CNT_W'(1);
            end
            else
            begin
                chk_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            issue_reg     <= '0;
            chk_valid_reg <= 1'b0;
            chk_slot_reg  <= '0;
        end
        else
        begin
            busy_reg      <= busy_next;
            issue_reg     <= issue_next;
            chk_valid_reg <= chk_valid_next;
            chk_slot_reg  <= chk_slot_next;
        end
    end

    a_start_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
        req.start |-> !busy_reg)
        else $error("search started while busy");

    a_no_write_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.wr_en)
        else $error("table written during a search");

    a_done_clears: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !busy_reg || $past(req.start))
        else $error("search still busy after done");

endmodule

// File: sv/assembler_token_lexer.sv
// Assembler lexer top level: character scanning, token building and output register.
//
// Usage: src_ch carries one item per transaction. opcode 0 gives a source
// character (zero ends the text and flushes a pending token); opcode 1 loads
// entry_text into mnemonic table slot entry_index. tok_ch carries tokens;
// last_of_run marks the final token caused by one item (at most two).
// cfg_we/cfg_wdata set mnemonic_count, the number of table slots searched.
// Processing: a load or a character that extends a word is taken in
// ST_IDLE alone. A character with no pending token passes through ST_CHAR;
// one that ends a pending token passes through ST_FLUSH and ST_CHAR, and
// first through ST_SEARCH when a word is looked up in up to N slots, N being
// min(mnemonic_count, TABLE_SLOTS): the table sits in one RAM with a registered
// read port, scanned one slot per cycle and stopped at the first match.
// Reset clears the scanner, the count and the output register; the table
// keeps its contents and slots must be loaded before they are searched.
// A stalled receiver holds the token in the output register; the scanner
// waits for the register to free before it writes the next token, and
// src_ch.ready stays low while an item is in progress.
module assembler_token_lexer import asmlex_pkg::*; #(
    parameter int MAX_TOKEN_CHARS = MAX_TOKEN_CHARS_DEF,
    parameter int TABLE_SLOTS     = TABLE_SLOTS_DEF,
    parameter int MNEMONIC_CHARS  = MNEMONIC_CHARS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    asmlex_in_if.sink          src_ch,
    asmlex_out_if.source       tok_ch,
    input  logic               cfg_we,
    input  logic [COUNT_W-1:0] cfg_wdata
);

    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam int CMP_W = 10;

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_SEARCH = 2'd1;
    localparam logic [1:0] ST_FLUSH  = 2'd2;
    localparam logic [1:0] ST_CHAR   = 2'd3;

    localparam logic [1:0] MODE_IDLE    = 2'd0;
    localparam logic [1:0] MODE_COMMAND = 2'd1;
    localparam logic [1:0] MODE_WORD    = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [1:0]         mode_reg, mode_next;
    logic [TEXT_W-1:0]  buf_reg, buf_next;
    logic [LEN_W-1:0]   len_reg, len_next;
    logic               ovf_reg, ovf_next;
    logic [CHAR_W-1:0]  char_reg, char_next;
    logic               hit_reg, hit_next;
    logic [INDEX_W-1:0] idx_reg, idx_next;
    logic [COUNT_W-1:0] count_reg;

    logic               tok_valid_reg, tok_valid_next;
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic [TEXT_W-1:0]  text_reg, text_next;
    logic [LEN_W-1:0]   olen_reg, olen_next;
    logic               trunc_reg, trunc_next;
    logic [INDEX_W-1:0] oidx_reg, oidx_next;
    logic               last_reg, last_next;

    logic [CNT_W-1:0]   limit;
    logic               accept;
    logic               out_free;
    logic               is_number;
    logic               char_emits;
    srch_req_t          srch_req;
    srch_rsp_t          srch_rsp;

    function automatic logic [TEXT_W-1:0] put_byte(logic [TEXT_W-1:0] text,
                                                   logic [LEN_W-1:0] pos,
                                                   logic [CHAR_W-1:0] c);
        logic [TEXT_W-1:0] r;
        r = text;
        for (int i = 0; i < TEXT_CHARS; i++)
        begin
            if (LEN_W'(i) == pos)
            begin
                r[i*CHAR_W +: CHAR_W] = c;
            end
        end
        return r;
    endfunction

    asmlex_search #(
        .TABLE_SLOTS    (TABLE_SLOTS),
        .MNEMONIC_CHARS (MNEMONIC_CHARS)
    ) u_search (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (srch_req),
        .limit       (limit),
        .word_text   (buf_reg[ENTRY_W-1:0]),
        .word_length (len_reg),
        .rsp         (srch_rsp)
    );

    assign limit = (CMP_W'(count_reg) > CMP_W'(TABLE_SLOTS)) ? CNT_W'(TABLE_SLOTS)
                                                              : CNT_W'(count_reg);

    assign src_ch.ready = (state_reg == ST_IDLE);
    assign accept       = src_ch.valid && src_ch.ready;
    assign out_free     = !tok_valid_reg || tok_ch.ready;
    assign is_number    = (buf_reg[CHAR_W-1:0] == CH_DOLLAR) ||
                          (buf_reg[CHAR_W-1:0] >= CH_ZERO && buf_reg[CHAR_W-1:0] <= CH_NINE);
    assign char_emits   = !(char_reg == CH_NUL || char_reg == CH_SPACE ||
                            char_reg == CH_DOT || is_word_char(char_reg));

    assign tok_ch.valid          = tok_valid_reg;
    assign tok_ch.token_kind     = kind_reg;
    assign tok_ch.token_text     = text_reg;
    assign tok_ch.token_length   = olen_reg;
    assign tok_ch.truncated      = trunc_reg;
    assign tok_ch.mnemonic_index = oidx_reg;
    assign tok_ch.last_of_run    = last_reg;

    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        buf_next       = buf_reg;
        len_next       = len_reg;
        ovf_next       = ovf_reg;
        char_next      = char_reg;
        hit_next       = hit_reg;
        idx_next       = idx_reg;
        tok_valid_next = tok_valid_reg && !tok_ch.ready;
        kind_next      = kind_reg;
        text_next      = text_reg;
        olen_next      = olen_reg;
        trunc_next     = trunc_reg;
        oidx_next      = oidx_reg;
        last_next      = last_reg;
        srch_req       = '0;

        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (src_ch.opcode)
                    begin
                        srch_req.wr_en   = (CMP_W'(src_ch.entry_index) < CMP_W'(TABLE_SLOTS));
                        srch_req.wr_addr = SLOT_FIELD_W'(src_ch.entry_index);
                        srch_req.wr_data = src_ch.entry_text;
                    end
                    else
                    begin
                        char_next = src_ch.char_in;
                        hit_next  = 1'b0;
                        if (mode_reg != MODE_IDLE)
                        begin
                            if (is_word_char(src_ch.char_in))
                            begin
                                // extend the pending token, or flag overflow when it is full
                                if (len_reg < LEN_W'(MAX_TOKEN_CHARS))
                                begin
                                    buf_next = put_byte(buf_reg, len_reg, src_ch.char_in);
                                    len_next = len_reg + 1'b1;
                                end
                                else
                                begin
                                    ovf_next = 1'b1;
                                end
                            end
                            else if (mode_reg == MODE_WORD && !is_number && !ovf_reg &&
                                     limit != '0)
                            begin
                                srch_req.start = 1'b1;
                                state_next     = ST_SEARCH;
                            end
                            else
                            begin
                                state_next = ST_FLUSH;
                            end
                        end
                        else
                        begin
                            state_next = ST_CHAR;
                        end
                    end
                end
            end
            ST_SEARCH:
            begin
                if (srch_rsp.done)
                begin
                    hit_next   = srch_rsp.hit;
                    idx_next   = srch_rsp.slot;
                    state_next = ST_FLUSH;
                end
            end
            ST_FLUSH:
            begin
                if (out_free)
                begin
                    tok_valid_next = 1'b1;
                    if (mode_reg == MODE_COMMAND)
                    begin
                        kind_next = KIND_COMMAND;
                    end
                    else if (is_number)
                    begin
                        kind_next = KIND_NUMBER;
                    end
                    else if (hit_reg)
                    begin
                        kind_next = KIND_MNEMONIC;
                    end
                    else
                    begin
                        kind_next = KIND_LABEL;
                    end
                    text_next  = buf_reg;
                    olen_next  = len_reg;
                    trunc_next = ovf_reg;
                    oidx_next  = (mode_reg == MODE_WORD && !is_number && hit_reg) ? idx_reg : '0;
                    last_next  = !char_emits;
                    mode_next  = MODE_IDLE;
                    buf_next   = '0;
                    len_next   = '0;
                    ovf_next   = 1'b0;
                    state_next = ST_CHAR;
                end
            end
            ST_CHAR:
            begin
                if (char_reg == CH_NUL || char_reg == CH_SPACE)
                begin
                    state_next = ST_IDLE;
                end
                else if (char_reg == CH_DOT)
                begin
                    mode_next  = MODE_COMMAND;
                    state_next = ST_IDLE;
                end
                else if (is_word_char(char_reg))
                begin
                    mode_next  = MODE_WORD;
                    buf_next   = put_byte(buf_reg, len_reg, char_reg);
                    len_next   = len_reg + 1'b1;
                    state_next = ST_IDLE;
                end
                else if (out_free)
                begin
                    tok_valid_next = 1'b1;
                    if (char_reg == CH_COLON)
                    begin
                        kind_next = KIND_COLON;
                    end
                    else if (char_reg == CH_NEWLINE)
                    begin
                        kind_next = KIND_EOL;
                    end
                    else if (char_reg == CH_HASH)
                    begin
                        kind_next = KIND_HASH;
                    end
                    else if (char_reg == CH_COMMA)
                    begin
                        kind_next = KIND_COMMA;
                    end
                    else
                    begin
                        kind_next = KIND_UNKNOWN;
                    end
                    text_next  = TEXT_W'(char_reg);
                    olen_next  = LEN_W'(1);
                    trunc_next = 1'b0;
                    oidx_next  = '0;
                    last_next  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_IDLE;
            buf_reg       <= '0;
            len_reg       <= '0;
            ovf_reg       <= 1'b0;
            hit_reg       <= 1'b0;
            count_reg     <= '0;
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            buf_reg       <= buf_next;
            len_reg       <= len_next;
            ovf_reg       <= ovf_next;
            hit_reg       <= hit_next;
            tok_valid_reg <= tok_valid_next;
            if (cfg_we)
            begin
                count_reg <= cfg_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg  <= char_next;
        idx_reg   <= idx_next;
        kind_reg  <= kind_next;
        text_reg  <= text_next;
        olen_reg  <= olen_next;
        trunc_reg <= trunc_next;
        oidx_reg  <= oidx_next;
        last_reg  <= last_next;
    end

    a_done_in_search: assert property (@(posedge clk) disable iff (!rst_n)
        srch_rsp.done |-> state_reg == ST_SEARCH)
        else $error("search result outside a lookup");

    a_overflow_full: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> len_reg == LEN_W'(MAX_TOKEN_CHARS))
        else $error("overflow flagged before the buffer filled");

    a_mnemonic_not_truncated: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_reg && kind_reg == KIND_MNEMONIC |-> !trunc_reg)
        else $error("truncated word reported as mnemonic");

    a_index_only_mnemonic: assert property (@(posedge clk) disable iff (!rst_n)
        tok_valid_reg && kind_reg != KIND_MNEMONIC |-> oidx_reg == '0)
        else $error("slot index on a non-mnemonic token");

endmodule
